// ----- rtl/fwm_pkg.sv -----
package fwm_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAX_FRAME    = 4096;
    localparam int TABLE_DEPTH  = 1024;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int PHASE_W = 24;
    localparam int POS_W   = $clog2(MAX_FRAME);
    localparam int LEN_W   = 13;
    localparam int MODE_W  = 2;
    localparam int COS_W   = 16;
    localparam int WGT_W   = 17;
    localparam int PROD_W  = SAMPLE_WIDTH + WGT_W + 1;
    localparam int CFG_W   = 24;
    localparam int CFGI_W  = 2;

    localparam logic [MODE_W-1:0] MODE_NONE    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HAMMING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_HANN    = 2'd2;

    localparam logic [CFGI_W-1:0] CFG_WINDOW_MODE  = 2'd0;
    localparam logic [CFGI_W-1:0] CFG_FRAME_LENGTH = 2'd1;
    localparam logic [CFGI_W-1:0] CFG_PHASE_STEP   = 2'd2;

    localparam logic [MODE_W-1:0]  RST_MODE   = MODE_NONE;
    localparam logic [LEN_W-1:0]   RST_LENGTH = 13'd4096;
    localparam logic [PHASE_W-1:0] RST_STEP   = 24'd4097;

    localparam logic signed [31:0] HAM_BIAS = 32'sd579846144;
    localparam logic signed [31:0] HAM_B    = 32'sd15073;

    localparam longint Q30_ONE     = 64'sd1073741824;
    localparam longint Q30_PI      = 64'sd3373259426;
    localparam longint Q30_HALF_PI = 64'sd1686629713;
    localparam longint Q30_TWO_PI  = 64'sd6746518852;
    localparam longint TAYLOR_DIV [8] = '{2, 12, 30, 56, 90, 132, 182, 240};

    typedef logic signed [COS_W-1:0] t_cos_rom [TABLE_DEPTH];

    typedef enum logic [1:0] {
        S_IDLE,
        S_WEIGHT,
        S_PRODUCT,
        S_OUTPUT
    } t_state;

    typedef struct packed {
        logic capture;
        logic weight;
        logic product;
        logic load_out;
    } t_ctrl_cmd;

    function automatic logic signed [COS_W-1:0] cos_entry(input int k);
        longint x;
        longint sum;
        longint term;
        longint r;
        logic   neg;
        x   = (longint'(k) * Q30_TWO_PI) / TABLE_DEPTH;
        neg = 1'b0;
        if (x > Q30_PI) x = Q30_TWO_PI - x;
        if (x > Q30_HALF_PI) begin
            x   = Q30_PI - x;
            neg = 1'b1;
        end
        sum  = Q30_ONE;
        term = Q30_ONE;
        for (int n = 0; n < 8; n++) begin
            term = (term * x) / Q30_ONE;
            term = (term * x) / Q30_ONE;
            term = -term / TAYLOR_DIV[n];
            sum  = sum + term;
        end
        if (neg) sum = -sum;
        r = ((sum + 4 * Q30_ONE + 64'sd16384) >>> 15) - 64'sd131072;
        if (r > 64'sd32767) r = 64'sd32767;
        if (r < -64'sd32768) r = -64'sd32768;
        return COS_W'(r);
    endfunction

    function automatic t_cos_rom cos_rom_init();
        t_cos_rom rom;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            rom[k] = cos_entry(k);
        end
        return rom;
    endfunction

endpackage

// ----- rtl/fwm_ctrl.sv -----
module fwm_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output fwm_pkg::t_ctrl_cmd   o_cmd
);

    fwm_pkg::t_state r_state;
    fwm_pkg::t_state n_state;
    logic            r_out_valid;
    logic            n_out_valid;
    logic            slot_free;

    assign slot_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            fwm_pkg::S_IDLE:    if (i_in_valid) n_state = fwm_pkg::S_WEIGHT;
            fwm_pkg::S_WEIGHT:  n_state = fwm_pkg::S_PRODUCT;
            fwm_pkg::S_PRODUCT: n_state = fwm_pkg::S_OUTPUT;
            fwm_pkg::S_OUTPUT:  if (slot_free) n_state = fwm_pkg::S_IDLE;
            default:            n_state = fwm_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            fwm_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            fwm_pkg::S_WEIGHT:  o_cmd.weight   = 1'b1;
            fwm_pkg::S_PRODUCT: o_cmd.product  = 1'b1;
            fwm_pkg::S_OUTPUT:  o_cmd.load_out = slot_free;
            default: begin
                o_in_ready = 1'b0;
                o_cmd      = '0;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= fwm_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_accept_to_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##3 (r_state == fwm_pkg::S_OUTPUT))
        else $error("item did not reach output stage in three cycles");

    a_load_into_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten while held");

    a_valid_from_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == fwm_pkg::S_OUTPUT))
        else $error("output valid raised outside output stage");

endmodule

// ----- rtl/fwm_datapath.sv -----
module fwm_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  fwm_pkg::t_ctrl_cmd                   i_cmd,
    input  logic signed [fwm_pkg::SAMPLE_WIDTH-1:0] i_sample,
    input  logic                                 i_cfg_valid,
    input  logic [fwm_pkg::CFGI_W-1:0]           i_cfg_index,
    input  logic [fwm_pkg::CFG_W-1:0]            i_cfg_data,
    output logic signed [fwm_pkg::SAMPLE_WIDTH-1:0] o_windowed_sample,
    output logic                                 o_frame_end
);

    localparam fwm_pkg::t_cos_rom COS_ROM = fwm_pkg::cos_rom_init();
    localparam int SW = fwm_pkg::SAMPLE_WIDTH;
    localparam logic signed [SW-1:0] SAT_MAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {1'b1, {(SW-1){1'b0}}};

    logic [fwm_pkg::MODE_W-1:0]  r_mode;
    logic [fwm_pkg::LEN_W-1:0]   r_length;
    logic [fwm_pkg::PHASE_W-1:0] r_step;
    logic [fwm_pkg::POS_W-1:0]   r_pos;
    logic [fwm_pkg::PHASE_W-1:0] r_phase;

    logic signed [SW-1:0]             r_sample;
    logic signed [fwm_pkg::COS_W-1:0] r_cos;
    logic                             r_end;
    logic [fwm_pkg::WGT_W-1:0]        r_wgt;
    logic signed [fwm_pkg::PROD_W-1:0] r_prod;
    logic signed [SW-1:0]             r_out;
    logic                             r_out_end;

    logic [fwm_pkg::LEN_W-1:0]   len_eff;
    logic [fwm_pkg::LEN_W-1:0]   len_m1;
    logic                        last;
    logic [fwm_pkg::IDX_W-1:0]   rom_idx;
    logic signed [31:0]          ham_q;
    logic [fwm_pkg::WGT_W-1:0]   hann_diff;
    logic [fwm_pkg::WGT_W-1:0]   n_wgt;
    logic signed [fwm_pkg::WGT_W:0] wgt_s;
    logic signed [fwm_pkg::PROD_W-1:0] rnd;
    logic signed [fwm_pkg::PROD_W-16:0] shifted;
    logic signed [SW-1:0]        sat;
    logic signed [SW-1:0]        n_out;
    logic                        windowed;

    always_comb begin
        if (r_length < fwm_pkg::LEN_W'(2)) begin
            len_eff = fwm_pkg::LEN_W'(2);
        end else if (r_length > fwm_pkg::LEN_W'(fwm_pkg::MAX_FRAME)) begin
            len_eff = fwm_pkg::LEN_W'(fwm_pkg::MAX_FRAME);
        end else begin
            len_eff = r_length;
        end
    end

    assign len_m1  = len_eff - fwm_pkg::LEN_W'(1);
    assign last    = {1'b0, r_pos} >= len_m1;
    assign rom_idx = r_phase[fwm_pkg::PHASE_W-1 -: fwm_pkg::IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= fwm_pkg::RST_MODE;
            r_length <= fwm_pkg::RST_LENGTH;
            r_step   <= fwm_pkg::RST_STEP;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                fwm_pkg::CFG_WINDOW_MODE:  r_mode   <= i_cfg_data[fwm_pkg::MODE_W-1:0];
                fwm_pkg::CFG_FRAME_LENGTH: r_length <= i_cfg_data[fwm_pkg::LEN_W-1:0];
                fwm_pkg::CFG_PHASE_STEP:   r_step   <= i_cfg_data[fwm_pkg::PHASE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= '0;
        end else if (i_cmd.capture) begin
            if (last) begin
                r_pos   <= '0;
                r_phase <= '0;
            end else begin
                r_pos   <= r_pos + fwm_pkg::POS_W'(1);
                r_phase <= r_phase + r_step;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_sample <= i_sample;
            r_cos    <= COS_ROM[rom_idx];
            r_end    <= last;
        end
    end

    assign ham_q     = fwm_pkg::HAM_BIAS - fwm_pkg::HAM_B * 32'(r_cos);
    assign hann_diff = fwm_pkg::WGT_W'(32768) - {r_cos[fwm_pkg::COS_W-1], r_cos};
    assign n_wgt     = (r_mode == fwm_pkg::MODE_HAMMING) ? ham_q[31:15]
                                                        : {1'b0, hann_diff[fwm_pkg::WGT_W-1:1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.weight) r_wgt <= n_wgt;
    end

    assign wgt_s = {1'b0, r_wgt};

    always_ff @(posedge i_clk) begin
        if (i_cmd.product) begin
            r_prod <= fwm_pkg::PROD_W'(r_sample) * fwm_pkg::PROD_W'(wgt_s);
        end
    end

    assign rnd     = r_prod + fwm_pkg::PROD_W'(16384);
    assign shifted = rnd[fwm_pkg::PROD_W-1:15];

    always_comb begin
        if (shifted > $signed({{(fwm_pkg::PROD_W-15-SW){1'b0}}, SAT_MAX})) begin
            sat = SAT_MAX;
        end else if (shifted < $signed({{(fwm_pkg::PROD_W-15-SW){1'b1}}, SAT_MIN})) begin
            sat = SAT_MIN;
        end else begin
            sat = shifted[SW-1:0];
        end
    end

    assign windowed = (r_mode == fwm_pkg::MODE_HAMMING) || (r_mode == fwm_pkg::MODE_HANN);
    assign n_out    = windowed ? sat : r_sample;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out     <= n_out;
            r_out_end <= r_end;
        end
    end

    assign o_windowed_sample = r_out;
    assign o_frame_end       = r_out_end;

endmodule

// ----- rtl/frame_window_multiplier_unit.sv -----
// Frame window multiplier: applies a Hamming or Hann weight to a sample stream, or passes it through.
// Input channel s_axis carries one signed sample per item; output channel m_axis
// carries the weighted sample with tlast high on the last sample of each frame.
// The weight comes from a 1024-entry cosine ROM indexed by the top bits of a
// 24-bit phase accumulator that adds phase_step per sample and clears at frame end.
// The config channel writes window_mode (0), frame_length (1) and phase_step (2);
// write it only while no item is in flight. o_cfg_ready is always high.
// Each item passes through the ROM read into the capture registers at the accept
// edge, then weight, product, and round and saturate into the output register.
// The controller steps one item through these stages before taking the next, so
// no new sample is accepted while an item is still in these stages.
// The output register frees the input side: a new item is accepted while a
// finished result waits. When the receiver stalls, the item in flight waits in
// its last stage and input stays blocked until the output register drains.
// Reset (synchronous, active low) clears position and phase, sets passthrough
// mode, frame length 4096 and phase step 4097, and empties the output register.
module frame_window_multiplier_unit (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  logic                                     s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  logic [fwm_pkg::SAMPLE_WIDTH-1:0]         s_axis_tdata,  // [15:0] sample
    output logic                                     m_axis_tvalid,
    input  logic                                     m_axis_tready,
    output logic [fwm_pkg::SAMPLE_WIDTH-1:0]         m_axis_tdata,  // [15:0] windowed_sample
    output logic                                     m_axis_tlast,
    input  logic                                     i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  logic [fwm_pkg::CFGI_W-1:0]               i_cfg_index,
    input  logic [fwm_pkg::CFG_W-1:0]                i_cfg_data
);

    fwm_pkg::t_ctrl_cmd                      cmd;
    logic signed [fwm_pkg::SAMPLE_WIDTH-1:0] windowed_sample;

    assign o_cfg_ready = 1'b1;

    fwm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    fwm_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_sample          ($signed(s_axis_tdata)),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_windowed_sample (windowed_sample),
        .o_frame_end       (m_axis_tlast)
    );

    assign m_axis_tdata = windowed_sample;

endmodule

// ----- sim/fwm_window_checker.sv -----
`timescale 1ns / 1ps

module fwm_window_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_ready,
    input  logic [fwm_pkg::SAMPLE_WIDTH-1:0] i_in_sample,
    input  logic                             i_out_valid,
    input  logic                             i_out_ready,
    input  logic [fwm_pkg::SAMPLE_WIDTH-1:0] i_out_sample,
    input  logic                             i_out_last,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [fwm_pkg::CFGI_W-1:0]       i_cfg_index,
    input  logic [fwm_pkg::CFG_W-1:0]        i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);

    localparam longint ANGLE_ONE     = 64'sd1073741824;
    localparam longint ANGLE_PI      = 64'sd3373259426;
    localparam longint ANGLE_HALF_PI = 64'sd1686629713;
    localparam longint ANGLE_TURN    = 64'sd6746518852;
    localparam longint HAMMING_BASE  = 64'sd17695;
    localparam longint HAMMING_SLOPE = 64'sd15073;
    localparam longint OUT_MAX       = (64'sd1 <<< (fwm_pkg::SAMPLE_WIDTH - 1)) - 1;
    localparam longint OUT_MIN       = -OUT_MAX - 1;

    typedef struct packed {
        logic [fwm_pkg::SAMPLE_WIDTH-1:0] sample;
        logic                             frame_end;
    } t_windowed_item;

    logic [fwm_pkg::MODE_W-1:0]  win_mode;
    logic [fwm_pkg::LEN_W-1:0]   win_len;
    logic [fwm_pkg::PHASE_W-1:0] win_step;
    logic [fwm_pkg::PHASE_W-1:0] phase_acc;
    int                          frame_pos;
    int                          result_count;
    int                          cos_lut [fwm_pkg::TABLE_DEPTH];
    t_windowed_item              expected_windowed [$];

    // cos(2*pi*k/TABLE_DEPTH) in Q1.15, folded into the first quadrant, Taylor series in Q30
    function automatic int cos_q15(input int k);
        longint ang;
        longint acc;
        longint term;
        longint rounded;
        bit     flip;
        ang  = (longint'(k) * ANGLE_TURN) / fwm_pkg::TABLE_DEPTH;
        flip = 1'b0;
        if (ang > ANGLE_PI) ang = ANGLE_TURN - ang;
        if (ang > ANGLE_HALF_PI) begin
            ang  = ANGLE_PI - ang;
            flip = 1'b1;
        end
        acc  = ANGLE_ONE;
        term = ANGLE_ONE;
        for (int n = 1; n <= 8; n++) begin
            term = (term * ang) / ANGLE_ONE;
            term = (term * ang) / ANGLE_ONE;
            term = -term / longint'((2 * n - 1) * (2 * n));
            acc  = acc + term;
        end
        if (flip) acc = -acc;
        rounded = ((acc + 4 * ANGLE_ONE + 64'sd16384) >> 15) - 64'sd131072;
        if (rounded > 64'sd32767) rounded = 64'sd32767;
        if (rounded < -64'sd32768) rounded = -64'sd32768;
        return int'(rounded);
    endfunction

    initial begin
        for (int k = 0; k < fwm_pkg::TABLE_DEPTH; k++) cos_lut[k] = cos_q15(k);
    end

    function automatic logic [fwm_pkg::SAMPLE_WIDTH-1:0] predict_windowed(
        input logic [fwm_pkg::SAMPLE_WIDTH-1:0] raw,
        input logic [fwm_pkg::PHASE_W-1:0]      ph
    );
        longint s;
        longint c;
        longint w;
        longint y;
        int     idx;
        idx = int'((longint'(ph) * fwm_pkg::TABLE_DEPTH) >> fwm_pkg::PHASE_W);
        c   = longint'(cos_lut[idx]);
        s   = longint'($signed(raw));
        case (win_mode)
            fwm_pkg::MODE_HAMMING: w = (HAMMING_BASE * 32768 - HAMMING_SLOPE * c + 16384) >>> 15;
            fwm_pkg::MODE_HANN:    w = (64'sd32768 - c) >>> 1;
            default:               return raw;
        endcase
        y = (s * w + 64'sd16384) >>> 15;
        if (y > OUT_MAX) y = OUT_MAX;
        if (y < OUT_MIN) y = OUT_MIN;
        return fwm_pkg::SAMPLE_WIDTH'(y);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] result %0d: %s got %0d, expected %0d",
                 $realtime, result_count, what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_windowed_item want;
        int             eff_len;
        if (!i_rst_n) begin
            win_mode     = fwm_pkg::RST_MODE;
            win_len      = fwm_pkg::RST_LENGTH;
            win_step     = fwm_pkg::RST_STEP;
            phase_acc    = '0;
            frame_pos    = 0;
            o_fail_count = 0;
            result_count = 0;
            expected_windowed.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    fwm_pkg::CFG_WINDOW_MODE:  win_mode = i_cfg_data[fwm_pkg::MODE_W-1:0];
                    fwm_pkg::CFG_FRAME_LENGTH: win_len  = i_cfg_data[fwm_pkg::LEN_W-1:0];
                    fwm_pkg::CFG_PHASE_STEP:   win_step = i_cfg_data[fwm_pkg::PHASE_W-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_windowed.size() == 0) begin
                    report_mismatch("result with nothing pending, sample",
                                    longint'($signed(i_out_sample)), 0);
                end else begin
                    want = expected_windowed.pop_front();
                    if (i_out_sample !== want.sample) begin
                        report_mismatch("windowed_sample", longint'($signed(i_out_sample)),
                                        longint'($signed(want.sample)));
                    end
                    if (i_out_last !== want.frame_end) begin
                        report_mismatch("frame_end", longint'(i_out_last),
                                        longint'(want.frame_end));
                    end
                end
                result_count++;
            end

            if (i_in_valid && i_in_ready) begin
                want.sample = predict_windowed(i_in_sample, phase_acc);
                eff_len     = int'(win_len);
                if (eff_len < 2) eff_len = 2;
                if (eff_len > fwm_pkg::MAX_FRAME) eff_len = fwm_pkg::MAX_FRAME;
                if (frame_pos >= eff_len - 1) begin
                    want.frame_end = 1'b1;
                    frame_pos      = 0;
                    phase_acc      = '0;
                end else begin
                    want.frame_end = 1'b0;
                    frame_pos++;
                    phase_acc = phase_acc + win_step;
                end
                expected_windowed.push_back(want);
            end
        end
        o_pending = expected_windowed.size();
    end

endmodule

// ----- sim/tb_frame_window_multiplier_unit.sv -----
`timescale 1ns / 1ps

module tb_frame_window_multiplier_unit;

    localparam logic [fwm_pkg::MODE_W-1:0] MODE_UNUSED  = 2'd3;
    localparam logic [fwm_pkg::CFGI_W-1:0] CFG_UNUSED   = 2'd3;
    localparam int                         RANDOM_ITEMS = 1950;
    localparam int                         STALL_LIMIT  = 2000;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [fwm_pkg::SAMPLE_WIDTH-1:0] s_axis_tdata;   // [15:0] sample
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [fwm_pkg::SAMPLE_WIDTH-1:0] m_axis_tdata;   // [15:0] windowed_sample
    logic                             m_axis_tlast;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [fwm_pkg::CFGI_W-1:0]       i_cfg_index;
    logic [fwm_pkg::CFG_W-1:0]        i_cfg_data;

    int fail_count;
    int pending;
    int idle_cycles;
    bit no_idle;

    frame_window_multiplier_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    fwm_window_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_sample  (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_sample (m_axis_tdata),
        .i_out_last   (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: hold off a random number of cycles after each item taken, unless no_idle is set
    initial begin
        int rx_wait;
        rx_wait       = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) rx_wait = no_idle ? 0 : $urandom_range(0, 5);
            @(negedge i_clk);
            if (rx_wait > 0) begin
                m_axis_tready <= 1'b0;
                rx_wait--;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    task automatic send_sample(input logic [fwm_pkg::SAMPLE_WIDTH-1:0] value);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [fwm_pkg::CFGI_W-1:0] index,
                             input logic [fwm_pkg::CFG_W-1:0]  value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic write_setup(input logic [fwm_pkg::MODE_W-1:0]  mode,
                               input logic [fwm_pkg::LEN_W-1:0]   len,
                               input logic [fwm_pkg::PHASE_W-1:0] step);
        cfg_write(fwm_pkg::CFG_WINDOW_MODE, fwm_pkg::CFG_W'(mode));
        cfg_write(fwm_pkg::CFG_FRAME_LENGTH, fwm_pkg::CFG_W'(len));
        cfg_write(fwm_pkg::CFG_PHASE_STEP, fwm_pkg::CFG_W'(step));
    endtask

    initial begin
        int                               sent;
        int                               batch;
        int                               eff_len;
        logic [fwm_pkg::MODE_W-1:0]       mode;
        logic [fwm_pkg::LEN_W-1:0]        len;
        logic [fwm_pkg::PHASE_W-1:0]      step;
        logic [fwm_pkg::SAMPLE_WIDTH-1:0] value;

        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = fwm_pkg::CFG_WINDOW_MODE;
        i_cfg_data    = '0;
        no_idle       = 1'b0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // settings out of reset: passthrough
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'hFFFF);
        drain_results();

        write_setup(fwm_pkg::MODE_HAMMING, 13'd5, 24'd4194304);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h3039);
        send_sample(16'h8000);
        drain_results();

        // short frame, half-turn step
        write_setup(fwm_pkg::MODE_HANN, 13'd0, 24'd8388608);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        drain_results();

        write_setup(MODE_UNUSED, 13'd1, 24'hFFFFFF);
        send_sample(16'h8000);
        send_sample(16'h5A5A);
        drain_results();

        // write to an unmapped index, then a long frame
        cfg_write(CFG_UNUSED, fwm_pkg::CFG_W'($urandom));
        write_setup(fwm_pkg::MODE_HAMMING, 13'd8191, 24'd0);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        drain_results();

        // lower the length part-way through a frame
        write_setup(fwm_pkg::MODE_HANN, 13'd8, 24'd2396745);
        repeat (6) send_sample(fwm_pkg::SAMPLE_WIDTH'($urandom));
        drain_results();
        cfg_write(fwm_pkg::CFG_FRAME_LENGTH, fwm_pkg::CFG_W'(3));
        send_sample(16'h7FFF);
        send_sample(16'hA5A5);
        drain_results();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 7))
                0:       mode = fwm_pkg::MODE_NONE;
                1:       mode = MODE_UNUSED;
                2, 3, 4: mode = fwm_pkg::MODE_HAMMING;
                default: mode = fwm_pkg::MODE_HANN;
            endcase
            case ($urandom_range(0, 9))
                0:       len = fwm_pkg::LEN_W'($urandom_range(0, 1));
                1:       len = 13'd4096;
                2:       len = fwm_pkg::LEN_W'($urandom_range(4097, 8191));
                3:       len = 13'd2;
                default: len = fwm_pkg::LEN_W'($urandom_range(3, 48));
            endcase
            eff_len = (len < 2) ? 2 : (len > fwm_pkg::MAX_FRAME) ? fwm_pkg::MAX_FRAME : int'(len);
            case ($urandom_range(0, 7))
                0:       step = fwm_pkg::PHASE_W'($urandom);
                1:       step = '0;
                2:       step = 24'hFFFFFF;
                3:       step = 24'd8388608;
                default: step = fwm_pkg::PHASE_W'((1 << fwm_pkg::PHASE_W) / (eff_len - 1));
            endcase
            write_setup(mode, len, step);
            no_idle = ($urandom_range(0, 3) == 0);
            batch   = $urandom_range(40, 120);
            repeat (batch) begin
                case ($urandom_range(0, 9))
                    0:       value = 16'h7FFF;
                    1:       value = 16'h8000;
                    2:       value = fwm_pkg::SAMPLE_WIDTH'($urandom_range(0, 8) - 4);
                    default: value = fwm_pkg::SAMPLE_WIDTH'($urandom);
                endcase
                send_sample(value);
            end
            sent += batch;
            drain_results();
        end

        no_idle = 1'b0;
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/fwm_pkg.sv
rtl/fwm_ctrl.sv
rtl/fwm_datapath.sv
rtl/frame_window_multiplier_unit.sv
sim/fwm_window_checker.sv
sim/tb_frame_window_multiplier_unit.sv
